>>> src/ame_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the accumulator machine execute unit.
// Used by the controller, the datapath and the top level.
package ame_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int WORD_BITS = 32;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int ADDR_BITS = 10;

   typedef enum logic [3:0] {
      ACT_PAUSE = 4'd0,
      ACT_SET   = 4'd1,
      ACT_LOAD  = 4'd2,
      ACT_ADD   = 4'd3,
      ACT_INC   = 4'd4,
      ACT_DEC   = 4'd5,
      ACT_STORE = 4'd6,
      ACT_SHOW  = 4'd7,
      ACT_END   = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      SHOW_MEM  = 2'd0,
      SHOW_ACC  = 2'd1,
      SHOW_MAR  = 2'd2,
      SHOW_MDR  = 2'd3
   } show_type;

   typedef enum logic [2:0] {
      REP_MEM   = 3'd0,
      REP_ACC   = 3'd1,
      REP_MAR   = 3'd2,
      REP_MDR   = 3'd3,
      REP_PAUSE = 3'd4,
      REP_END   = 3'd5
   } report_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH_B,
      ST_EXEC
   } state_type;

   typedef enum logic [1:0] {
      AS_REQ_A,
      AS_B,
      AS_DEST,
      AS_CLEAR
   } addr_sel_type;

   typedef struct packed {
      logic         clear;
      logic         load;
      logic         latch_a;
      logic         exec;
      addr_sel_type addr_sel;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic exec_stall;
   } status_type;

   function automatic logic in_range(input logic [ADDR_BITS-1:0] addr);
      logic [31:0] ext;
      ext = 32'(addr);
      return ext < 32'(MEM_WORDS);
   endfunction

endpackage

>>> src/accumulator_machine_execute_unit.sv
`timescale 1ns / 1ps
// Top level of the accumulator machine execute unit.
// Depends on ame_pkg, ame_ctrl, ame_dpath and ame_ram.
//
// Each input word is one decoded instruction, executed on a 1024-word memory, an
// accumulator, an address register and a data register. After reset the memory is
// cleared in one pass, during which no word is accepted. Each instruction passes
// idle, fetch and execute: the single memory port reads the first operand, reads the
// second operand, and writes the result. SHW, PAUSE and END deliver one result word
// through an output register; a new instruction may be accepted while it waits, and
// the next reporting instruction holds in its execute cycle until that word is taken.
module accumulator_machine_execute_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // addr_a, addr_b, addr_c, has_second, has_third, immediate, show_target, zero fill
   input  logic [71:0]  req_tdata,
   // action
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // shown_value, acc_value, mar_value, mdr_value, bad_address, zero fill
   output logic [111:0] rsp_tdata,
   // report_kind
   output logic [2:0]   rsp_tuser
);

   ame_pkg::cmd_type    cmd;
   ame_pkg::status_type status;

   ame_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ame_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> src/ame_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with one write port and a registered read.
// Stands alone; no package needed.
module ame_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ame_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: memory clearing pass, instruction fetch phases, execute.
// Depends on ame_pkg.
module ame_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ame_pkg::status_type   status,
   output ame_pkg::cmd_type      cmd
);

   ame_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ame_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ame_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ame_pkg::ST_IDLE;
            end
         end
         ame_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ame_pkg::ST_FETCH_B;
            end
         end
         ame_pkg::ST_FETCH_B: begin
            state_in = ame_pkg::ST_EXEC;
         end
         ame_pkg::ST_EXEC: begin
            if (!status.exec_stall) begin
               state_in = ame_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ame_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd.clear    = 1'b0;
      cmd.load     = 1'b0;
      cmd.latch_a  = 1'b0;
      cmd.exec     = 1'b0;
      cmd.addr_sel = ame_pkg::AS_REQ_A;
      case (state_ff)
         ame_pkg::ST_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.addr_sel = ame_pkg::AS_CLEAR;
         end
         ame_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load     = req_tvalid;
            cmd.addr_sel = ame_pkg::AS_REQ_A;
         end
         ame_pkg::ST_FETCH_B: begin
            cmd.latch_a  = 1'b1;
            cmd.addr_sel = ame_pkg::AS_B;
         end
         ame_pkg::ST_EXEC: begin
            cmd.exec     = !status.exec_stall;
            cmd.addr_sel = ame_pkg::AS_DEST;
         end
         default: begin
            cmd.addr_sel = ame_pkg::AS_REQ_A;
         end
      endcase
   end

endmodule

>>> src/ame_dpath.sv
`timescale 1ns / 1ps
// Datapath: instruction register, word memory, first-operand register, adder,
// accumulator, address and data registers, and the result register.
// Depends on ame_pkg and ame_ram.
module ame_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  ame_pkg::cmd_type      cmd,
   output ame_pkg::status_type   status,
   input  logic [71:0]           req_tdata,
   input  logic [3:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [111:0]          rsp_tdata,
   output logic [2:0]            rsp_tuser
);

   localparam int WB = ame_pkg::WORD_BITS;
   localparam int AB = ame_pkg::ADDR_BITS;
   localparam int AW = ame_pkg::MEM_AW;

   logic [3:0]    action_ff;
   logic [AB-1:0] a_ff, b_ff, c_ff;
   logic          has2_ff, has3_ff;
   logic [WB-1:0] imm_ff;
   logic [1:0]    tgt_ff;

   logic [WB-1:0] opa_ff;
   logic [WB-1:0] acc_ff, acc_in;
   logic [AB-1:0] mar_ff, mar_in;
   logic [WB-1:0] mdr_ff, mdr_in;
   logic [AW-1:0] clr_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    kind_ff, kind_in;
   logic [WB-1:0] shown_ff, shown_in;
   logic [WB-1:0] racc_ff, rmdr_ff;
   logic [AB-1:0] rmar_ff;
   logic          bad_ff, bad_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [WB-1:0] ram_wdata, ram_rdata;

   logic          reports, writes;
   logic [AB-1:0] dest;
   logic [WB-1:0] opb, add_x, add_y, sum;

   ame_ram #(.WIDTH(WB), .DEPTH(ame_pkg::MEM_WORDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      reports = 1'b0;
      writes  = 1'b0;
      dest    = a_ff;
      case (action_ff)
         ame_pkg::ACT_PAUSE, ame_pkg::ACT_SHOW, ame_pkg::ACT_END: begin
            reports = 1'b1;
         end
         ame_pkg::ACT_SET, ame_pkg::ACT_INC, ame_pkg::ACT_DEC, ame_pkg::ACT_STORE: begin
            writes = 1'b1;
         end
         ame_pkg::ACT_ADD: begin
            writes = has3_ff;
            dest   = c_ff;
         end
         default: begin
            reports = 1'b0;
         end
      endcase
   end

   assign status.clear_last = (clr_ff == AW'(ame_pkg::MEM_WORDS - 1));
   assign status.exec_stall = reports && rsp_valid_ff && !rsp_tready;

   always_comb begin
      case (cmd.addr_sel)
         ame_pkg::AS_REQ_A: ram_addr = AW'(req_tdata[9:0]);
         ame_pkg::AS_B:     ram_addr = AW'(b_ff);
         ame_pkg::AS_DEST:  ram_addr = AW'(dest);
         ame_pkg::AS_CLEAR: ram_addr = clr_ff;
         default:           ram_addr = clr_ff;
      endcase
   end

   assign opb = ame_pkg::in_range(b_ff) ? ram_rdata : '0;

   always_comb begin
      add_x = opa_ff;
      add_y = opb;
      case (action_ff)
         ame_pkg::ACT_ADD: begin
            if (!has2_ff && !has3_ff) begin
               add_x = acc_ff;
               add_y = opa_ff;
            end
         end
         ame_pkg::ACT_INC: add_y = WB'(1);
         ame_pkg::ACT_DEC: add_y = '1;
         default:          add_y = opb;
      endcase
   end

   assign sum = add_x + add_y;

   always_comb begin
      ram_wdata = sum;
      case (action_ff)
         ame_pkg::ACT_SET:   ram_wdata = imm_ff;
         ame_pkg::ACT_STORE: ram_wdata = acc_ff;
         default:            ram_wdata = sum;
      endcase
      if (cmd.clear) begin
         ram_wdata = '0;
      end
   end

   assign ram_we = cmd.clear || (cmd.exec && writes && ame_pkg::in_range(dest));

   always_comb begin
      acc_in = acc_ff;
      mar_in = mar_ff;
      mdr_in = mdr_ff;
      if (cmd.exec) begin
         case (action_ff)
            ame_pkg::ACT_SET: begin
               mar_in = a_ff;
               mdr_in = imm_ff;
            end
            ame_pkg::ACT_LOAD: begin
               acc_in = opa_ff;
               mar_in = a_ff;
               mdr_in = opa_ff;
            end
            ame_pkg::ACT_ADD: begin
               if (has3_ff) begin
                  mar_in = c_ff;
                  mdr_in = sum;
               end else if (has2_ff) begin
                  acc_in = sum;
                  mar_in = b_ff;
                  mdr_in = sum;
               end else begin
                  acc_in = sum;
               end
            end
            ame_pkg::ACT_INC, ame_pkg::ACT_DEC: begin
               acc_in = sum;
               mar_in = a_ff;
               mdr_in = sum;
            end
            ame_pkg::ACT_STORE: begin
               mar_in = a_ff;
               mdr_in = acc_ff;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_comb begin
      kind_in  = kind_ff;
      shown_in = shown_ff;
      bad_in   = bad_ff;
      if (cmd.exec && reports) begin
         bad_in   = 1'b0;
         shown_in = acc_ff;
         case (action_ff)
            ame_pkg::ACT_PAUSE: kind_in = ame_pkg::REP_PAUSE;
            ame_pkg::ACT_END:   kind_in = ame_pkg::REP_END;
            default: begin
               kind_in = {1'b0, tgt_ff};
               case (tgt_ff)
                  ame_pkg::SHOW_MEM: begin
                     shown_in = opa_ff;
                     bad_in   = !ame_pkg::in_range(a_ff);
                  end
                  ame_pkg::SHOW_ACC: shown_in = acc_ff;
                  ame_pkg::SHOW_MAR: shown_in = WB'(mar_ff);
                  ame_pkg::SHOW_MDR: shown_in = mdr_ff;
                  default:           shown_in = mdr_ff;
               endcase
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec && reports) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         mar_ff       <= '0;
         mdr_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         mar_ff       <= mar_in;
         mdr_ff       <= mdr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_tuser;
         a_ff      <= req_tdata[9:0];
         b_ff      <= req_tdata[19:10];
         c_ff      <= req_tdata[29:20];
         has2_ff   <= req_tdata[30];
         has3_ff   <= req_tdata[31];
         imm_ff    <= req_tdata[63:32];
         tgt_ff    <= req_tdata[65:64];
      end
      if (cmd.latch_a) begin
         opa_ff <= ame_pkg::in_range(a_ff) ? ram_rdata : '0;
      end
      kind_ff  <= kind_in;
      shown_ff <= shown_in;
      bad_ff   <= bad_in;
      if (cmd.exec && reports) begin
         racc_ff <= acc_ff;
         rmar_ff <= mar_ff;
         rmdr_ff <= mdr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {5'd0, bad_ff, rmdr_ff, rmar_ff, racc_ff, shown_ff};

endmodule
